// ===== src/bre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bre_pkg;

    localparam int POS_W         = 10;
    localparam int CNT_W         = 11;
    localparam int MODE_W        = 2;
    localparam int POS_SPAN      = 1 << POS_W;
    localparam int DEF_BITS      = 1024;
    localparam int DEF_WORD_BITS = 8;

    localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic capture;
        logic div;
        logic mask;
        logic rd;
        logic done;
    } bre_cmd_t;

    typedef struct packed {
        logic skip;
        logic rd_last;
    } bre_stat_t;

endpackage

`default_nettype wire

// ===== src/bre_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bre_datapath #(
    parameter int BITS      = bre_pkg::DEF_BITS,
    parameter int WORD_BITS = bre_pkg::DEF_WORD_BITS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  bre_pkg::bre_cmd_t                cmd,
    output bre_pkg::bre_stat_t               stat,
    input  wire  [bre_pkg::MODE_W-1:0]       in_mode,
    input  wire  [bre_pkg::POS_W-1:0]        in_first,
    input  wire  [bre_pkg::POS_W-1:0]        in_last,
    output logic [bre_pkg::CNT_W-1:0]        res_count,
    output logic                             res_error
);

    localparam int WORD_COUNT = (BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int SPAN_WORDS = (bre_pkg::POS_SPAN + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH      = (WORD_COUNT < SPAN_WORDS) ? WORD_COUNT : SPAN_WORDS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int PC_W       = $clog2(WORD_BITS + 1);
    // quotient by reciprocal: exact for positions below 2^10
    localparam int DIV_SH     = 20;
    localparam int RECIP      = (1 << DIV_SH) / WORD_BITS + 1;

    localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

    logic [bre_pkg::MODE_W-1:0] mode_reg;
    logic [bre_pkg::POS_W-1:0]  first_reg;
    logic [bre_pkg::POS_W-1:0]  last_reg;
    logic                       err_reg;
    logic                       skip_reg;
    logic [AW-1:0]              wlo_reg;
    logic [AW-1:0]              whi_reg;
    logic [WORD_BITS-1:0]       lo_mask_reg;
    logic [WORD_BITS-1:0]       hi_mask_reg;
    logic [AW-1:0]              rd_ptr_reg;
    logic [AW-1:0]              proc_ptr_reg;
    logic                       proc_vld_reg;
    logic                       rd_vld_reg;
    logic [WORD_BITS-1:0]       q_reg;
    logic [DEPTH-1:0]           vld_reg;
    logic [bre_pkg::CNT_W-1:0]  count_reg;

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [bre_pkg::POS_W-1:0] last_clip;
    logic                      in_err;
    logic [31:0]               prod_lo;
    logic [31:0]               prod_hi;
    logic [31:0]               rem_lo;
    logic [31:0]               rem_hi;
    logic [BW-1:0]             b_lo;
    logic [BW-1:0]             b_hi;
    logic [WORD_BITS-1:0]      word_mask;
    logic [WORD_BITS-1:0]      cur_word;
    logic [WORD_BITS-1:0]      hit;
    logic [WORD_BITS-1:0]      new_word;
    logic [PC_W-1:0]           pop;
    logic                      wr_en;

    assign in_err    = in_first > in_last;
    assign last_clip = (32'(in_last) >= 32'(BITS)) ? bre_pkg::POS_W'(BITS - 1) : in_last;

    assign prod_lo = 32'(first_reg) * 32'(RECIP);
    assign prod_hi = 32'(last_reg) * 32'(RECIP);

    assign rem_lo = 32'(first_reg) - 32'(wlo_reg) * 32'(WORD_BITS);
    assign rem_hi = 32'(last_reg) - 32'(whi_reg) * 32'(WORD_BITS);
    assign b_lo   = rem_lo[BW-1:0];
    assign b_hi   = rem_hi[BW-1:0];

    // words never written read as zero
    assign cur_word  = rd_vld_reg ? q_reg : '0;
    assign word_mask = ((proc_ptr_reg == wlo_reg) ? lo_mask_reg : WORD_ONES)
                     & ((proc_ptr_reg == whi_reg) ? hi_mask_reg : WORD_ONES);
    assign hit       = cur_word & word_mask;
    assign new_word  = (mode_reg == bre_pkg::MODE_SET) ? (cur_word | word_mask)
                                                       : (cur_word & ~word_mask);
    assign wr_en     = proc_vld_reg
                     && ((mode_reg == bre_pkg::MODE_SET) || (mode_reg == bre_pkg::MODE_CLEAR));

    always_comb begin
        pop = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            pop = pop + PC_W'(hit[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            first_reg <= in_first;
            last_reg  <= last_clip;
            err_reg   <= in_err;
            skip_reg  <= in_err || (in_mode inside {bre_pkg::MODE_UNUSED})
                      || (32'(in_first) >= 32'(BITS));
        end
        if (cmd.div) begin
            wlo_reg <= prod_lo[DIV_SH +: AW];
            whi_reg <= prod_hi[DIV_SH +: AW];
        end
        if (cmd.mask) begin
            lo_mask_reg <= WORD_ONES << b_lo;
            hi_mask_reg <= WORD_ONES >> (BW'(WORD_BITS - 1) - b_hi);
            rd_ptr_reg  <= wlo_reg;
        end else if (cmd.rd) begin
            rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
        if (cmd.rd) begin
            proc_ptr_reg <= rd_ptr_reg;
            rd_vld_reg   <= vld_reg[rd_ptr_reg];
        end
        if (cmd.capture) begin
            count_reg <= '0;
        end else if (proc_vld_reg && (mode_reg == bre_pkg::MODE_COUNT)) begin
            count_reg <= count_reg + bre_pkg::CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[proc_ptr_reg] <= new_word;
        end
        if (cmd.rd) begin
            q_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_vld_reg <= 1'b0;
            vld_reg      <= '0;
        end else begin
            proc_vld_reg <= cmd.rd;
            if (wr_en) begin
                vld_reg[proc_ptr_reg] <= 1'b1;
            end
        end
    end

    assign stat.skip    = skip_reg;
    assign stat.rd_last = rd_ptr_reg == whi_reg;
    assign res_count    = count_reg;
    assign res_error    = err_reg;

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> (rd_ptr_reg >= wlo_reg) && (rd_ptr_reg <= whi_reg))
        else $error("word read outside the request range");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_vld_reg |=> count_reg <= bre_pkg::CNT_W'(bre_pkg::POS_SPAN))
        else $error("bit count beyond map span");

endmodule

`default_nettype wire

// ===== src/bre_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bre_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 out_free,
    output bre_pkg::bre_cmd_t   cmd,
    input  bre_pkg::bre_stat_t  stat
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_MASK  = 6'b000100,
        ST_WALK  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_DIV;
            ST_DIV:   state_next = stat.skip ? ST_RESP : ST_MASK;
            ST_MASK:  state_next = ST_WALK;
            ST_WALK:  if (stat.rd_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_RESP;
            ST_RESP:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready    = state_reg == ST_IDLE;
    assign cmd.capture = (state_reg == ST_IDLE) && in_valid;
    assign cmd.div     = state_reg == ST_DIV;
    assign cmd.mask    = state_reg == ST_MASK;
    assign cmd.rd      = state_reg == ST_WALK;
    assign cmd.done    = (state_reg == ST_RESP) && out_free;

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) && stat.rd_last |=> state_reg == ST_DRAIN)
        else $error("word walk did not end at last word");

endmodule

`default_nettype wire

// ===== src/bitmap_range_engine_unit.sv =====
// channel   dir  handshake         payload
// s_        in   s_tvalid/tready   tdata: first_bit, last_bit; tuser: mode
// m_        out  m_tvalid/tready   tdata: bits_counted; tuser: range_error
//
// A request walks n = last/WORD_BITS - first/WORD_BITS + 1 words,
// one word per cycle through the bitmap memory's read and write ports.
// Reversed, unused-mode and out-of-map requests skip the word walk.
// Reset clears the map at once through per-word valid flags.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result finds that register full.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_range_engine_unit #(
    parameter int BITS      = bre_pkg::DEF_BITS,
    parameter int WORD_BITS = bre_pkg::DEF_WORD_BITS
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // first_bit[9:0], last_bit[19:10], zero pad
    input  wire  [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // bits_counted[10:0], zero pad
    output logic [0:0]  m_tuser    // range_error[0]
);

    bre_pkg::bre_cmd_t  cmd;
    bre_pkg::bre_stat_t stat;

    logic [bre_pkg::CNT_W-1:0] res_count;
    logic                      res_error;
    logic                      out_free;

    logic                      m_tvalid_reg;
    logic [bre_pkg::CNT_W-1:0] count_out_reg;
    logic                      error_out_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    bre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .cmd      (cmd),
        .stat     (stat)
    );

    bre_datapath #(
        .BITS      (BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_mode   (s_tuser[bre_pkg::MODE_W-1:0]),
        .in_first  (s_tdata[bre_pkg::POS_W-1:0]),
        .in_last   (s_tdata[2*bre_pkg::POS_W-1:bre_pkg::POS_W]),
        .res_count (res_count),
        .res_error (res_error)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.done) begin
            count_out_reg <= res_count;
            error_out_reg <= res_error;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {5'd0, count_out_reg};
    assign m_tuser[0] = error_out_reg;

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_error_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("reversed range reported a count");

endmodule

`default_nettype wire
